FILE: hw/rtl/pfs_pkg.sv
// Shared types and constants of the photon Fourier sketch.
package pfs_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_REAL  = 2'd0,
    KIND_IMAG  = 2'd1,
    KIND_TOTAL = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_NUM_HARMONICS = 2'd0,
    REG_PHASE_PER_BIN = 2'd1,
    REG_HIST_LEN      = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_e;

  typedef struct packed {
    logic [4:0]  num_harmonics;
    logic [15:0] phase_per_bin;
    logic [15:0] hist_len;
  } cfg_t;

  localparam logic [4:0]  NUM_HARMONICS_RST = 5'd5;
  localparam logic [15:0] PHASE_PER_BIN_RST = 16'd428;
  localparam logic [15:0] HIST_LEN_RST      = 16'd153;

  // Quarter-wave sine polynomial, Q30 coefficients
  localparam logic [31:0] SIN_A   = 32'd1686629713;
  localparam logic [31:0] SIN_B   = 32'd688904866;
  localparam logic [31:0] SIN_C   = 32'd76016977;
  localparam logic [23:0] QUARTER = 24'h400000;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

endpackage

FILE: hw/rtl/photon_fourier_sketch.sv
// Photon Fourier sketch: top level with sequencer, shared multiplier and sketch RAM.
//
// Input stream (s_*): one transfer per command. tuser carries the command
// (add photon, read and clear pixel, end frame); tdata carries pixel, bin
// and counts. Output stream (m_*): coefficient, frame total or bin error
// results; tlast marks the final result of a command.
// An add photon updates m harmonics, real then imaginary:
// each accumulator update runs five passes through the one 32x32 multiplier
// (x^2, two polynomial terms, final product, count scaling) plus one RAM
// read-modify-write. A read steps through each of the pixel's
// 2*MAX_HARMONICS entries, since all of them are cleared. s_tready is high
// only between commands.
// After reset the sketch RAM is zeroed one entry per cycle
// (NUM_PIXELS*MAX_HARMONICS*2 entries) before the first transfer is taken;
// APB writes are accepted throughout.
// Results sit in one output register; while the receiver stalls, the
// sequencer holds before loading the next result and nothing is lost.
module photon_fourier_sketch #(
  parameter int NUM_PIXELS    = 1024,
  parameter int MAX_HARMONICS = 16,
  parameter int PHASE_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pixel[9:0], bin[25:10], counts[41:26], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // harmonic[3:0], value[51:4], zero pad
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);
  import pfs_pkg::*;

  localparam int Depth  = NUM_PIXELS * MAX_HARMONICS * 2;
  localparam int AddrW  = $clog2(Depth);
  localparam int HW     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int Lim    = (MAX_HARMONICS < 16) ? MAX_HARMONICS : 16;
  localparam logic [23:0] Keep = 24'hFFFFFF << (24 - PHASE_BITS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_STEP, S_STEP_W, S_HARM, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_ACC, S_FTOT, S_RD, S_RD_W, S_RD_E, S_EMIT
  } state_e;

  cfg_t cfg;

  pfs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  state_e            state_q;
  logic [AddrW-1:0]  clr_q;
  logic [15:0]       bin_q, counts_q;
  logic              pix_ok_q;
  logic [AddrW-1:0]  base_q;
  logic [15:0]       step_q, phase_q;
  logic [HW-1:0]     h_q;
  logic              part_q;
  logic [22:0]       x_q, x2_q;
  logic              neg_q;
  logic [31:0]       ftot_q;
  // pending single result
  logic [1:0]        ekind_q;
  logic [47:0]       evalue_q;
  // output register
  logic              ovalid_q;
  logic [1:0]        okind_q;
  logic [3:0]        oharm_q;
  logic [47:0]       ovalue_q;
  logic              olast_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  pfs_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // sketch memory
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_addr;
  logic [47:0]      ram_wdata, ram_rdata;

  pfs_ram #(.Width(48), .Depth(Depth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(ram_re), .raddr_i(ram_addr), .rdata_o(ram_rdata)
  );

  // effective harmonic count
  logic [4:0] m_eff;
  always_comb begin
    if (cfg.num_harmonics == 5'd0) begin
      m_eff = 5'd1;
    end else if (32'(cfg.num_harmonics) > Lim) begin
      m_eff = 5'(Lim);
    end else begin
      m_eff = cfg.num_harmonics;
    end
  end

  // input fields
  cmd_e        in_cmd;
  logic [9:0]  in_pix;
  logic [15:0] in_bin, in_counts;
  assign in_cmd    = cmd_e'(s_tuser);
  assign in_pix    = s_tdata[9:0];
  assign in_bin    = s_tdata[25:10];
  assign in_counts = s_tdata[41:26];

  // entry address within pixel
  logic [AddrW-1:0] addr_cur;
  assign addr_cur = base_q + (part_q ? AddrW'(MAX_HARMONICS) : AddrW'(0)) + AddrW'(h_q);

  // phase of current harmonic; cosine runs a quarter turn ahead
  logic [15:0] ph_cur;
  logic [23:0] ph24, ph_sel;
  logic [21:0] frac;
  assign ph_cur = part_q ? phase_q : phase_q + step_q;
  assign ph24   = {ph_cur, 8'd0} & Keep;
  assign ph_sel = part_q ? ph24 : ph24 + QUARTER;
  assign frac   = ph_sel[21:0];

  // saturating accumulate
  logic signed [31:0] delta;
  logic signed [49:0] acc_sum;
  logic        [47:0] acc_sat;
  assign delta   = neg_q ? -$signed({1'b0, prod[30:0]}) : $signed({1'b0, prod[30:0]});
  assign acc_sum = 50'($signed(ram_rdata)) + 50'(delta);
  always_comb begin
    if (acc_sum > 50'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < 50'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum[47:0];
    end
  end

  logic        out_free;
  logic        out_load;
  logic        last_h;
  logic [32:0] ftot_sum;
  assign out_free = !ovalid_q || m_tready;
  assign out_load = out_free && ((state_q == S_EMIT) ||
                                 (state_q == S_RD_E && 8'(h_q) < 8'(m_eff)));
  assign last_h   = (h_q == HW'(MAX_HARMONICS - 1));
  assign ftot_sum = {1'b0, ftot_q} + 33'(counts_q);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = addr_cur;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_addr  = addr_cur;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_STEP: begin
        mul_a = 32'(bin_q);
        mul_b = 32'(cfg.phase_per_bin);
      end
      S_HARM:  ram_re = 1'b1;
      S_M1: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      S_M2: begin
        mul_a = SIN_C;
        mul_b = 32'(prod[44:22]);
      end
      S_M3: begin
        mul_a = SIN_B - 32'(prod[58:22]);
        mul_b = 32'(x2_q);
      end
      S_M4: begin
        mul_a = SIN_A - 32'(prod[58:22]);
        mul_b = 32'(x_q);
      end
      S_M5: begin
        mul_a = 32'(counts_q);
        mul_b = 32'(prod[52:37] + 16'(prod[36]));
      end
      S_ACC: begin
        ram_we    = 1'b1;
        ram_wdata = acc_sat;
      end
      S_RD:    ram_re = pix_ok_q;
      S_RD_E:  ram_we = pix_ok_q && (8'(h_q) >= 8'(m_eff) || out_free);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ftot_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= out_load || (ovalid_q && !m_tready);
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(Depth - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            bin_q    <= in_bin;
            counts_q <= in_counts;
            pix_ok_q <= 32'(in_pix) < NUM_PIXELS;
            base_q   <= AddrW'(in_pix) * AddrW'(2 * MAX_HARMONICS);
            h_q      <= '0;
            part_q   <= 1'b0;
            unique case (in_cmd)
              CMD_ADD: begin
                if (in_bin >= cfg.hist_len) begin
                  ekind_q  <= KIND_ERROR;
                  evalue_q <= 48'(in_bin);
                  state_q  <= S_EMIT;
                end else if (32'(in_pix) < NUM_PIXELS) begin
                  state_q <= S_STEP;
                end
              end
              CMD_READ:  state_q <= S_RD;
              CMD_FRAME: begin
                ekind_q  <= KIND_TOTAL;
                evalue_q <= 48'(ftot_q);
                ftot_q   <= '0;
                state_q  <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_STEP:   state_q <= S_STEP_W;
        S_STEP_W: begin
          step_q  <= prod[15:0];
          phase_q <= '0;
          state_q <= S_HARM;
        end
        S_HARM: begin
          phase_q <= ph_cur;
          x_q     <= ph_sel[22] ? 23'(QUARTER) - 23'(frac) : 23'(frac);
          neg_q   <= ph_sel[23];
          state_q <= S_M1;
        end
        S_M1: state_q <= S_M2;
        S_M2: begin
          x2_q    <= prod[44:22];
          state_q <= S_M3;
        end
        S_M3: state_q <= S_M4;
        S_M4: state_q <= S_M5;
        S_M5: state_q <= S_ACC;
        S_ACC: begin
          part_q <= !part_q;
          if (!part_q) begin
            state_q <= S_HARM;
          end else if (8'(h_q) + 8'd1 == 8'(m_eff)) begin
            state_q <= S_FTOT;
          end else begin
            h_q     <= h_q + HW'(1);
            state_q <= S_HARM;
          end
        end
        S_FTOT: begin
          ftot_q  <= ftot_sum[32] ? 32'hFFFF_FFFF : ftot_sum[31:0];
          state_q <= S_IDLE;
        end
        S_RD:   state_q <= S_RD_W;
        S_RD_W: state_q <= S_RD_E;
        S_RD_E: begin
          if (8'(h_q) >= 8'(m_eff) || out_free) begin
            if (8'(h_q) < 8'(m_eff)) begin
              okind_q  <= part_q ? KIND_IMAG : KIND_REAL;
              oharm_q  <= 4'(h_q);
              ovalue_q <= pix_ok_q ? ram_rdata : '0;
              olast_q  <= part_q && (8'(h_q) + 8'd1 == 8'(m_eff));
            end
            if (last_h) begin
              h_q    <= '0;
              part_q <= 1'b1;
              state_q <= part_q ? S_IDLE : S_RD;
            end else begin
              h_q     <= h_q + HW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            okind_q  <= ekind_q;
            oharm_q  <= '0;
            ovalue_q <= evalue_q;
            olast_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = ovalid_q;
  assign m_tdata  = {4'd0, ovalue_q, oharm_q};
  assign m_tuser  = okind_q;
  assign m_tlast  = olast_q;

endmodule

FILE: hw/rtl/pfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module pfs_ram #(
  parameter int Width = 48,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pfs_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module pfs_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/pfs_cfg.sv
// APB register file: harmonic count, phase step and histogram length.
module pfs_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pfs_pkg::cfg_t cfg_o
);
  import pfs_pkg::*;

  cfg_t  cfg_q;
  reg_e  sel;
  logic  wr;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_harmonics <= NUM_HARMONICS_RST;
      cfg_q.phase_per_bin <= PHASE_PER_BIN_RST;
      cfg_q.hist_len      <= HIST_LEN_RST;
    end else if (wr) begin
      unique case (sel)
        REG_NUM_HARMONICS: cfg_q.num_harmonics <= pwdata[4:0];
        REG_PHASE_PER_BIN: cfg_q.phase_per_bin <= pwdata[15:0];
        REG_HIST_LEN:      cfg_q.hist_len      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_NUM_HARMONICS: prdata = 32'(cfg_q.num_harmonics);
      REG_PHASE_PER_BIN: prdata = 32'(cfg_q.phase_per_bin);
      REG_HIST_LEN:      prdata = 32'(cfg_q.hist_len);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/pfs_checker.sv
// Port-level checks of the photon Fourier sketch, bound to the top level.
module pfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import pfs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // single-result kinds always close their run
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == KIND_TOTAL || m_tuser == KIND_ERROR) |-> m_tlast)
    else $error("total or error result without tlast");

  a_single_harm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == KIND_TOTAL || m_tuser == KIND_ERROR) |-> m_tdata[3:0] == 4'd0)
    else $error("nonzero harmonic on total or error result");

  // a read transfer keeps the block busy
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser == CMD_READ |=> !s_tready)
    else $error("ready right after a read transfer");

  // real coefficients never close a run
  a_real_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == KIND_REAL |-> !m_tlast)
    else $error("real coefficient marked last");

endmodule

bind photon_fourier_sketch pfs_checker u_pfs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
